@@ rtl/core/kvt_pkg.sv @@
// Shared types and codes for the key/value table.
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int REQ_W = 2;
    localparam int ST_W  = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load_req;  // capture the incoming item, restart the slot counter
        logic scan_rd;   // read the slot under the counter, advance
        logic sweep_wr;  // mark the slot under the counter free, advance
        logic finish;    // apply the table update, load the result register
    } t_kvt_cmd;

    // Datapath to controller
    typedef struct packed {
        logic addr_last;  // slot counter sits on the last slot
        logic req_clear;  // captured item is a clear
        logic out_free;   // result register can take a new result this cycle
    } t_kvt_sts;

endpackage

`default_nettype wire

@@ rtl/core/kvt_ctrl.sv @@
// Sequencer for the key/value table: init sweep, slot scan and finish.
`timescale 1ns / 1ps
`default_nettype none

module kvt_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire kvt_pkg::t_kvt_sts    i_sts,
    output kvt_pkg::t_kvt_cmd         o_cmd
);
    import kvt_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd  = !i_sts.req_clear;
                o_cmd.sweep_wr = i_sts.req_clear;
                if (i_sts.addr_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/kvt_datapath.sv @@
// Slot memories, key comparator, scan registers and result register.
`timescale 1ns / 1ps
`default_nettype none

module kvt_datapath #(
    parameter int ENTRIES = kvt_pkg::ENTRIES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire kvt_pkg::t_kvt_cmd          i_cmd,
    output kvt_pkg::t_kvt_sts               o_sts,
    input  wire logic [kvt_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [kvt_pkg::KEY_W-1:0]  i_key,
    input  wire logic [kvt_pkg::VAL_W-1:0]  i_value,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [kvt_pkg::ST_W-1:0]        o_status,
    output logic                            o_found,
    output logic [kvt_pkg::VAL_W-1:0]       o_read_value
);
    import kvt_pkg::*;

    localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KMW  = KEY_W + 1;  // valid mark on top of the key
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    // Slot memories
    logic [KMW-1:0]   r_key_mem [ENTRIES];
    logic [VAL_W-1:0] r_val_mem [ENTRIES];

    // Captured item
    logic [REQ_W-1:0] r_req;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;

    // Scan
    logic [AW-1:0]    r_addr;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_addr;
    logic [KMW-1:0]   r_kd;
    logic [VAL_W-1:0] r_vd;
    logic             r_hit;
    logic [AW-1:0]    r_hit_idx;
    logic [VAL_W-1:0] r_hit_val;
    logic             r_free;
    logic [AW-1:0]    r_free_idx;

    // Result register
    logic             r_out_vld;
    logic [ST_W-1:0]  r_status;
    logic             r_found;
    logic [VAL_W-1:0] r_rdval;

    logic             key_we;
    logic [AW-1:0]    key_wa;
    logic [KMW-1:0]   key_wd;
    logic             val_we;
    logic [AW-1:0]    val_wa;
    logic             slot_vld;
    logic             slot_match;
    logic [ST_W-1:0]  n_status;
    logic             n_found;
    logic [VAL_W-1:0] n_rdval;

    assign o_sts.addr_last = (r_addr == LAST);
    assign o_sts.req_clear = (r_req == REQ_CLEAR);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    // Write port selection: sweep clears a valid mark, finish applies the update
    always_comb begin
        key_we = 1'b0;
        key_wa = r_addr;
        key_wd = '0;
        val_we = 1'b0;
        val_wa = r_hit_idx;
        if (i_cmd.sweep_wr) begin
            key_we = 1'b1;
        end else if (i_cmd.finish) begin
            if (r_req == REQ_INSERT) begin
                if (r_hit) begin
                    val_we = 1'b1;
                end else if (r_free) begin
                    key_we = 1'b1;
                    key_wa = r_free_idx;
                    key_wd = {1'b1, r_key};
                    val_we = 1'b1;
                    val_wa = r_free_idx;
                end
            end else if (r_req == REQ_REMOVE && r_hit) begin
                key_we = 1'b1;
                key_wa = r_hit_idx;
                key_wd = {1'b0, r_key};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[key_wa] <= key_wd;
        end
        if (i_cmd.scan_rd) begin
            r_kd <= r_key_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[val_wa] <= r_val;
        end
        if (i_cmd.scan_rd) begin
            r_vd <= r_val_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_type;
            r_key <= i_key;
            r_val <= i_value;
        end
        if (i_cmd.scan_rd) begin
            r_rd_addr <= r_addr;
        end
    end

    assign slot_vld   = r_kd[KMW-1];
    assign slot_match = slot_vld && (r_kd[KEY_W-1:0] == r_key);

    // Counter, read pipe and first hit / first free capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.load_req) begin
                r_addr <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else begin
                if (i_cmd.scan_rd || i_cmd.sweep_wr) begin
                    r_addr <= (r_addr == LAST) ? '0 : r_addr + 1'b1;
                end
                if (r_rd_vld && slot_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (r_rd_vld && !slot_vld && !r_free) begin
                    r_free <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && slot_match && !r_hit) begin
            r_hit_idx <= r_rd_addr;
            r_hit_val <= r_vd;
        end
        if (r_rd_vld && !slot_vld && !r_free) begin
            r_free_idx <= r_rd_addr;
        end
    end

    always_comb begin
        n_status = ST_OK;
        n_found  = 1'b0;
        n_rdval  = '0;
        case (r_req)
            REQ_LOOKUP: begin
                n_found = r_hit;
                if (r_hit) begin
                    n_rdval = r_hit_val;
                end else begin
                    n_status = ST_MISSING;
                end
            end
            REQ_INSERT: begin
                n_found = r_hit;
                if (!r_hit && !r_free) begin
                    n_status = ST_FULL;
                end
            end
            REQ_REMOVE: begin
                n_found = r_hit;
                if (!r_hit) begin
                    n_status = ST_MISSING;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_rdval  <= n_rdval;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_read_value = r_rdval;

    a_finish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_vld || i_out_ready))
        else $error("result loaded over an untaken result");

    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.scan_rd && i_cmd.sweep_wr) && !(i_cmd.finish && i_cmd.sweep_wr))
        else $error("conflicting slot memory commands");

    a_rd_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_rd |=> r_rd_vld)
        else $error("slot read did not reach the comparator");

    a_clear_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req == REQ_CLEAR) && !i_cmd.load_req |=> !i_cmd.scan_rd)
        else $error("slot scan during a clear");

endmodule

`default_nettype wire

@@ rtl/core/key_value_table.sv @@
// Top level of the key/value table: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Bounded associative table of ENTRIES unique 32-bit keys, each holding a
// 32-bit value. Each input item is a lookup, insert/update, remove or clear,
// and each gives exactly one result item (status, found, read_value). One
// key comparator walks the slots in index order out of a single-port slot
// memory, so an item is accepted, scanned slot by slot, and after a wait
// state its result is loaded into the output register once that register
// is free; only then is the next item taken. A clear sweeps the valid marks
// with the same slot counter in place of the scan. After reset the block
// clears every slot in a first pass with o_in_ready low. The result
// register lets the next item enter while a result still waits on
// i_out_ready; only when a second result is done before the first is taken
// does the sequencer hold.
module key_value_table #(
    parameter int ENTRIES = kvt_pkg::ENTRIES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [kvt_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [kvt_pkg::KEY_W-1:0]  i_key,
    input  wire logic [kvt_pkg::VAL_W-1:0]  i_value,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [kvt_pkg::ST_W-1:0]        o_status,
    output logic                            o_found,
    output logic [kvt_pkg::VAL_W-1:0]       o_read_value
);
    import kvt_pkg::*;

    t_kvt_cmd cmd;
    t_kvt_sts sts;

    // Sequence init sweep, scan, finish
    kvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold slots, compare keys, build the result item
    kvt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_read_value (o_read_value)
    );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the key/value table: driver, monitor and predictor.
`timescale 1ns / 1ps

module testbench;

    import kvt_pkg::*;

    localparam int SLOTS       = ENTRIES_DEF;
    localparam int POOL_SIZE   = 24;     // more keys than slots, so the table fills
    localparam int PHASE_ITEMS = 280;
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off under pressure
    localparam int IDLE_LIMIT  = 3000;   // cycles with no item accepted on any channel
    localparam int DRAIN_WAIT  = 2 * SLOTS + 8;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } kv_req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic             found;
        logic [VAL_W-1:0] read_value;
    } kv_result_t;

    // Clock, reset and block inputs, all at known values from time zero.
    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic [REQ_W-1:0] i_req_type   = REQ_LOOKUP;
    logic [KEY_W-1:0] i_key        = '0;
    logic [VAL_W-1:0] i_value      = '0;
    logic             i_out_ready  = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [ST_W-1:0]  o_status;
    logic             o_found;
    logic [VAL_W-1:0] o_read_value;

    // Stimulus and scoreboard storage.
    kv_req_t    req_queue[$];        // requests waiting to be offered
    kv_result_t expected_results[$]; // predicted results, oldest first

    // Shadow copy of the table, updated as each request is accepted.
    logic [KEY_W-1:0] shadow_keys[SLOTS];
    logic [VAL_W-1:0] shadow_values[SLOTS];
    bit               shadow_valid[SLOTS];

    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_req       = 0;   // bumped by the sequencer to request a hold-off
    int  hold_seen      = 0;
    int  hold_left      = 0;
    bit  in_acc         = 1'b0; // an input item was accepted at the last rising edge
    int  quiet_cycles   = 0;
    int  fail_count     = 0;
    int  items_sent     = 0;
    int  lookup_hits    = 0;
    int  full_inserts   = 0;
    int  removes_done   = 0;
    int  clears_done    = 0;

    key_value_table #(
        .ENTRIES      (SLOTS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_read_value (o_read_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the shadow table and return the result it gives.
    // Only valid slots take part in a match; a new key takes the lowest free slot.
    function automatic kv_result_t table_apply(input kv_req_t r);
        kv_result_t res;
        int         hit;
        int         free_idx;
        res      = '{status: ST_OK, found: 1'b0, read_value: '0};
        hit      = -1;
        free_idx = -1;
        if (r.req == REQ_CLEAR) begin
            // Clear frees every slot whatever the key; nothing is looked up.
            for (int i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;
            return res;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && shadow_valid[i] && shadow_keys[i] == r.key) hit = i;
            if (free_idx < 0 && !shadow_valid[i]) free_idx = i;
        end
        res.found = (hit >= 0);
        case (r.req)
            REQ_LOOKUP: begin
                if (hit >= 0) res.read_value = shadow_values[hit];
                else res.status = ST_MISSING;
            end
            REQ_INSERT: begin
                if (hit >= 0) begin
                    shadow_values[hit] = r.value;       // update in place
                end else if (free_idx >= 0) begin
                    shadow_keys[free_idx]   = r.key;
                    shadow_values[free_idx] = r.value;
                    shadow_valid[free_idx]  = 1'b1;
                end else begin
                    res.status = ST_FULL;               // table left unchanged
                end
            end
            default: begin                              // remove
                if (hit >= 0) shadow_valid[hit] = 1'b0;
                else res.status = ST_MISSING;
            end
        endcase
        return res;
    endfunction

    task automatic push_req(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
        req_queue.push_back('{req: req, key: key, value: value});
    endtask

    // Random request: mostly keys from a small pool so hits, updates and a full
    // table come up often; the rest use arbitrary keys as noise.
    function automatic kv_req_t random_request();
        kv_req_t r;
        int      op;
        op      = $urandom_range(99);
        r.value = $urandom;
        if ($urandom_range(9) == 0) r.key = $urandom;
        else r.key = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (op < 34) r.req = REQ_LOOKUP;
        else if (op < 70) r.req = REQ_INSERT;
        else if (op < 96) r.req = REQ_REMOVE;
        else r.req = REQ_CLEAR;
        return r;
    endfunction

    // Driver: change inputs on the falling edge. Hold valid and payload until
    // the item is taken, then offer the next one or idle.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_acc)) begin
            if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                kv_req_t nxt;
                nxt = req_queue.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= nxt.req;
                i_key      <= nxt.key;
                i_value    <= nxt.value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here when asked for.
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor and predictor: sample on the rising edge. Check the result first;
    // a result at this edge always belongs to an older item than the one taken.
    always @(posedge i_clk) begin
        bit in_fire;
        bit out_fire;
        in_fire  = i_rst_n && (i_in_valid === 1'b1) && (o_in_ready === 1'b1);
        out_fire = i_rst_n && (o_out_valid === 1'b1) && (i_out_ready === 1'b1);
        in_acc <= in_fire;

        if (out_fire) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: status=%0d found=%0d value=%h",
                       o_status, o_found, o_read_value);
                fail_count++;
            end else begin
                kv_result_t exp_res;
                exp_res = expected_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    fail_count++;
                end
                if (o_found !== exp_res.found) begin
                    $error("found: expected %0d, got %0d", exp_res.found, o_found);
                    fail_count++;
                end
                if (o_read_value !== exp_res.read_value) begin
                    $error("read_value: expected %h, got %h", exp_res.read_value, o_read_value);
                    fail_count++;
                end
            end
        end

        if (in_fire) begin
            kv_req_t    taken;
            kv_result_t pred;
            taken = '{req: i_req_type, key: i_key, value: i_value};
            pred  = table_apply(taken);
            expected_results.push_back(pred);
            items_sent++;
            if (taken.req == REQ_LOOKUP && pred.found) lookup_hits++;
            if (pred.status == ST_FULL) full_inserts++;
            if (taken.req == REQ_REMOVE && pred.found) removes_done++;
            if (taken.req == REQ_CLEAR) clears_done++;
        end

        // Watchdog: drop the run if nothing moves for too long.
        if (in_fire || out_fire) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved in %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sequencer: reset, directed requests, then random phases with idling.
    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            shadow_keys[i]   = '0;
            shadow_values[i] = '0;
            shadow_valid[i]  = 1'b0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes of key and value, every request type, head removal,
        // a full table and an update while full.
        push_req(REQ_LOOKUP, 32'h0000_0000, $urandom);          // miss on empty table
        push_req(REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
        push_req(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(REQ_LOOKUP, 32'hFFFF_FFFF, $urandom);
        push_req(REQ_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);     // update in place
        push_req(REQ_LOOKUP, 32'h0000_0000, $urandom);
        push_req(REQ_REMOVE, 32'h0000_0000, $urandom);          // frees the head slot
        push_req(REQ_REMOVE, 32'h0000_0000, $urandom);          // now absent
        push_req(REQ_CLEAR, $urandom, $urandom);
        push_req(REQ_LOOKUP, 32'hFFFF_FFFF, $urandom);          // gone after clear
        for (int i = 0; i < SLOTS; i++) push_req(REQ_INSERT, 32'h0000_0100 + i, $urandom);
        push_req(REQ_INSERT, 32'h8000_0000, $urandom);          // no free slot
        push_req(REQ_INSERT, 32'h0000_0105, 32'h5A5A_A5A5);     // update while full
        push_req(REQ_CLEAR, $urandom, $urandom);
        while (req_queue.size() != 0) @(posedge i_clk);

        // Phase: no idling, with one long receiver hold-off to back up the block.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = hold_req + 1;
        for (int i = 0; i < PHASE_ITEMS; i++) req_queue.push_back(random_request());
        while (req_queue.size() != 0) @(posedge i_clk);

        // Phase: sender idles often.
        send_idle_pct = 58;
        for (int i = 0; i < PHASE_ITEMS; i++) req_queue.push_back(random_request());
        while (req_queue.size() != 0) @(posedge i_clk);

        // Phase: receiver stalls often.
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        for (int i = 0; i < PHASE_ITEMS; i++) req_queue.push_back(random_request());
        while (req_queue.size() != 0) @(posedge i_clk);

        // Phase: both sides idle now and then.
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        for (int i = 0; i < PHASE_ITEMS; i++) req_queue.push_back(random_request());

        // Drain: wait for the last item to go in and every result to come out.
        while (req_queue.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d requests: %0d lookup hits, %0d removals, %0d rejected inserts, %0d clears,",
                 items_sent, lookup_hits, removes_done, full_inserts, clears_done);
        $display("across phases with no idling, sender gaps, receiver stalls and both.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/kvt_pkg.sv
rtl/core/kvt_ctrl.sv
rtl/core/kvt_datapath.sv
rtl/core/key_value_table.sv
test/testbench.sv
